>>> src/cesc_pkg.sv
// Shared types, constants and character helpers of the C escape decoder.
`timescale 1ns / 1ps

package cesc_pkg;

   // Character codes
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;

   // Largest first octal digit that still allows a third digit
   localparam logic [5:0] OCT_HIGH_MAX = 6'd3;

   // Result kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_END_OK  = 2'd1;
   localparam logic [1:0] KIND_END_BAD = 2'd2;

   // Most results one input word can cause
   localparam int MAX_RESULTS = 3;

   // Parser mode, one-hot
   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_ESC    = 6'b000010,
      MODE_OCT    = 6'b000100,
      MODE_HEX0   = 6'b001000,
      MODE_HEX    = 6'b010000,
      MODE_ERROR  = 6'b100000
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  digit_count;
      logic [8:0]  escape_value;
      logic        zero_seen;
      logic [15:0] emitted_count;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      mode:          MODE_NORMAL,
      digit_count:   2'd0,
      escape_value:  9'd0,
      zero_seen:     1'b0,
      emitted_count: 16'd0
   };

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  kind;
      logic        run_last;
      logic [15:0] out_length;
   } result_type;

   // Results caused by one input word, entry 0 first
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] entry;
      logic [1:0]                   count;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Value of a hex digit character
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.value = c[3:0];
      end else if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                   (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   // Byte of a simple escape, zero when the character is not one
   function automatic logic [7:0] simple_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h27, 8'h22, 8'h3F, 8'h5C: r = c;
         8'h61: r = 8'd7;
         8'h62: r = 8'd8;
         8'h66: r = 8'd12;
         8'h6E: r = 8'd10;
         8'h72: r = 8'd13;
         8'h74: r = 8'd9;
         8'h76: r = 8'd11;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/cesc_if.sv
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface cesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface cesc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  kind;
   logic        run_last;
   logic [15:0] out_length;

   modport source (output valid, output out_byte, output kind, output run_last,
                   output out_length, input ready);
   modport sink   (input valid, input out_byte, input kind, input run_last,
                   input out_length, output ready);
endinterface

>>> src/cesc_decode.sv
// Next-state and result logic for one raw byte of the escaped string.
`timescale 1ns / 1ps

module cesc_decode (
   input  cesc_pkg::parse_state_type state_cur,
   input  logic [7:0]                in_byte,
   input  logic                      is_last,
   output cesc_pkg::parse_state_type state_nxt,
   output cesc_pkg::bundle_type      bundle
);

   cesc_pkg::parse_state_type st;
   cesc_pkg::hex_digit_type   hexd;
   logic [7:0] simp;
   logic       is_oct;
   logic       flush_a;
   logic [7:0] val_a;
   logic       data_b;
   logic [7:0] byte_b;
   logic       flush_c;
   logic [7:0] val_c;
   logic [1:0] n;
   cesc_pkg::result_type [cesc_pkg::MAX_RESULTS-1:0] res;

   assign hexd   = cesc_pkg::hex_decode(in_byte);
   assign simp   = cesc_pkg::simple_escape(in_byte);
   assign is_oct = (in_byte >= cesc_pkg::CHAR_ZERO) && (in_byte <= cesc_pkg::CHAR_SEVEN);

   always_comb begin
      st      = state_cur;
      flush_a = 1'b0;
      val_a   = 8'd0;
      data_b  = 1'b0;
      byte_b  = 8'd0;
      flush_c = 1'b0;
      val_c   = 8'd0;
      n       = 2'd0;
      res     = '0;

      // mode transition; flush_a is a pending escape ended by this byte
      unique case (state_cur.mode)
         cesc_pkg::MODE_ERROR: begin
         end
         cesc_pkg::MODE_ESC: begin
            if (simp != 8'd0) begin
               st.mode = cesc_pkg::MODE_NORMAL;
               data_b  = 1'b1;
               byte_b  = simp;
            end else if (is_oct) begin
               st.mode         = cesc_pkg::MODE_OCT;
               st.digit_count  = 2'd1;
               st.escape_value = {6'd0, in_byte[2:0]};
            end else if (in_byte == cesc_pkg::CHAR_LOWER_X) begin
               st.mode         = cesc_pkg::MODE_HEX0;
               st.digit_count  = 2'd0;
               st.escape_value = 9'd0;
            end else begin
               st.mode = cesc_pkg::MODE_ERROR;
            end
         end
         cesc_pkg::MODE_OCT: begin
            if (is_oct) begin
               if (state_cur.digit_count < 2'd2) begin
                  st.escape_value = {state_cur.escape_value[5:0], in_byte[2:0]};
                  st.digit_count  = 2'd2;
               end else if (state_cur.escape_value[8:3] > cesc_pkg::OCT_HIGH_MAX) begin
                  st.mode = cesc_pkg::MODE_ERROR;
               end else begin
                  st.escape_value = {state_cur.escape_value[5:0], in_byte[2:0]};
                  flush_a         = 1'b1;
                  val_a           = {state_cur.escape_value[4:0], in_byte[2:0]};
                  st.mode         = cesc_pkg::MODE_NORMAL;
                  st.digit_count  = 2'd0;
               end
            end else begin
               flush_a = 1'b1;
               val_a   = state_cur.escape_value[7:0];
            end
         end
         cesc_pkg::MODE_HEX0: begin
            if (hexd.valid) begin
               st.mode         = cesc_pkg::MODE_HEX;
               st.digit_count  = 2'd1;
               st.escape_value = {5'd0, hexd.value};
            end else begin
               st.mode = cesc_pkg::MODE_ERROR;
            end
         end
         cesc_pkg::MODE_HEX: begin
            if (hexd.valid) begin
               if (state_cur.digit_count < 2'd2) begin
                  st.escape_value = {state_cur.escape_value[4:0], hexd.value};
                  st.digit_count  = 2'd2;
               end else begin
                  st.mode = cesc_pkg::MODE_ERROR;
               end
            end else begin
               flush_a = 1'b1;
               val_a   = state_cur.escape_value[7:0];
            end
         end
         default: begin
         end
      endcase

      // a byte that is taken as plain text after ending an escape, or in normal mode
      if (flush_a && !is_oct && !hexd.valid ||
          flush_a && state_cur.mode == cesc_pkg::MODE_OCT && !is_oct ||
          state_cur.mode == cesc_pkg::MODE_NORMAL ||
          !(state_cur.mode == cesc_pkg::MODE_ESC || state_cur.mode == cesc_pkg::MODE_OCT ||
            state_cur.mode == cesc_pkg::MODE_HEX0 || state_cur.mode == cesc_pkg::MODE_HEX ||
            state_cur.mode == cesc_pkg::MODE_ERROR)) begin
         if (in_byte == cesc_pkg::CHAR_BACKSLASH) begin
            st.mode         = cesc_pkg::MODE_ESC;
            st.digit_count  = 2'd0;
            st.escape_value = 9'd0;
         end else begin
            st.mode = cesc_pkg::MODE_NORMAL;
            data_b  = 1'b1;
            byte_b  = in_byte;
         end
      end

      // escape ended by this byte
      if (flush_a) begin
         if (val_a == 8'd0) begin
            st.zero_seen = 1'b1;
         end else if (!st.zero_seen) begin
            res[n] = '{out_byte: val_a, kind: cesc_pkg::KIND_DATA, run_last: 1'b0,
                       out_length: 16'd0};
            n = n + 2'd1;
            if (st.emitted_count != 16'hFFFF) st.emitted_count = st.emitted_count + 16'd1;
         end
      end

      // plain byte or simple escape
      if (data_b && !st.zero_seen) begin
         res[n] = '{out_byte: byte_b, kind: cesc_pkg::KIND_DATA, run_last: 1'b0,
                    out_length: 16'd0};
         n = n + 2'd1;
         if (st.emitted_count != 16'hFFFF) st.emitted_count = st.emitted_count + 16'd1;
      end

      // end of string: close any pending escape, then report status
      if (is_last) begin
         if (st.mode == cesc_pkg::MODE_ESC || st.mode == cesc_pkg::MODE_HEX0) begin
            st.mode = cesc_pkg::MODE_ERROR;
         end else if (st.mode == cesc_pkg::MODE_OCT || st.mode == cesc_pkg::MODE_HEX) begin
            flush_c = 1'b1;
            val_c   = st.escape_value[7:0];
         end
         if (flush_c) begin
            if (val_c == 8'd0) begin
               st.zero_seen = 1'b1;
            end else if (!st.zero_seen) begin
               res[n] = '{out_byte: val_c, kind: cesc_pkg::KIND_DATA, run_last: 1'b0,
                          out_length: 16'd0};
               n = n + 2'd1;
               if (st.emitted_count != 16'hFFFF) st.emitted_count = st.emitted_count + 16'd1;
            end
         end
         if (st.mode == cesc_pkg::MODE_ERROR) begin
            res[n] = '{out_byte: 8'd0, kind: cesc_pkg::KIND_END_BAD, run_last: 1'b0,
                       out_length: 16'd0};
         end else begin
            res[n] = '{out_byte: 8'd0, kind: cesc_pkg::KIND_END_OK, run_last: 1'b0,
                       out_length: st.emitted_count};
         end
         n  = n + 2'd1;
         st = cesc_pkg::PARSE_RESET;
      end

      // mark the final result of this word
      if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;
   end

   assign state_nxt    = st;
   assign bundle.entry = res;
   assign bundle.count = n;

endmodule

>>> src/cesc_out_queue.sv
// Result register: holds the words of one input byte and hands them out one a cycle while the receiver is ready.
`timescale 1ns / 1ps

module cesc_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cesc_pkg::bundle_type bundle,
   output logic                 can_accept,
   cesc_rsp_if.source           rsp_if
);

   cesc_pkg::result_type [cesc_pkg::MAX_RESULTS-1:0] entry_ff, entry_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop        = rsp_if.valid && rsp_if.ready;
   assign can_accept = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_if.ready);

   // load a fresh group or shift the head out
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = bundle.entry;
         count_in = bundle.count;
      end else if (pop) begin
         for (int i = 0; i < cesc_pkg::MAX_RESULTS - 1; i++) entry_in[i] = entry_ff[i + 1];
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign rsp_if.valid      = (count_ff != 2'd0);
   assign rsp_if.out_byte   = entry_ff[0].out_byte;
   assign rsp_if.kind       = entry_ff[0].kind;
   assign rsp_if.run_last   = entry_ff[0].run_last;
   assign rsp_if.out_length = entry_ff[0].out_length;

endmodule

>>> src/c_escape_unescaper_core.sv
// Top level of the C string escape decoder.
//
// Usage: raw string bytes enter on req_if, one per word, with is_last set on
// the final byte of each string. Decoded words leave on rsp_if: data words
// (kind 0) carry a decoded byte, and each string closes with one end word
// (kind 1 good, with the decoded length saturated at 65535; kind 2 bad
// escape). run_last marks the final response word caused by a request word.
// The first response word of a request appears in the cycle after it is
// accepted. Throughput, while the receiver is ready: one request word per
// cycle while each causes at most one response word; a request that causes
// more (up to three) holds the input until the single response register,
// draining one word per cycle, holds its last word. Requests that cause no
// word (a backslash, a digit of a pending escape) pass at one per cycle.
// Reset clears the parser state and empties the response register. When the
// receiver stalls, the held response word stays put and req_if.ready drops
// once the response register cannot take the next group.
`timescale 1ns / 1ps

module c_escape_unescaper_core (
   input  logic       clock,
   input  logic       reset,
   cesc_req_if.sink   req_if,
   cesc_rsp_if.source rsp_if
);

   cesc_pkg::parse_state_type state_ff, state_in;
   cesc_pkg::bundle_type      bundle;
   logic                      accept;
   logic                      can_accept;

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;

   cesc_decode u_decode (
      .state_cur (state_ff),
      .in_byte   (req_if.in_byte),
      .is_last   (req_if.is_last),
      .state_nxt (state_in),
      .bundle    (bundle)
   );

   // parser state advances on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cesc_pkg::PARSE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   cesc_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle     (bundle),
      .can_accept (can_accept),
      .rsp_if     (rsp_if)
   );

endmodule

>>> src/cesc_checker.sv
// Port-level checks for the escape decoder, bound to the top level.
`timescale 1ns / 1ps

module cesc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_kind,
   input logic        rsp_run_last,
   input logic [15:0] rsp_out_length
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind)
         && $stable(rsp_run_last) && $stable(rsp_out_length))
      else $error("response word changed while stalled");

   // the final byte of a string always produces at least its end word
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> rsp_valid)
      else $error("no response after final byte");

   // an end word is always the final word of its request
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != cesc_pkg::KIND_DATA |-> rsp_run_last)
      else $error("end word without run_last");

   // kind is a defined code and data/bad words carry no length
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == cesc_pkg::KIND_DATA || rsp_kind == cesc_pkg::KIND_END_OK ||
                     rsp_kind == cesc_pkg::KIND_END_BAD)
         && (rsp_kind == cesc_pkg::KIND_END_OK || rsp_out_length == 16'd0))
      else $error("bad kind or length on response");

   // end words carry a zero byte
   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != cesc_pkg::KIND_DATA |-> rsp_out_byte == 8'd0)
      else $error("end word with non-zero byte");

endmodule

bind c_escape_unescaper_core cesc_checker u_cesc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_is_last    (req_if.is_last),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_byte   (rsp_if.out_byte),
   .rsp_kind       (rsp_if.kind),
   .rsp_run_last   (rsp_if.run_last),
   .rsp_out_length (rsp_if.out_length)
);

>>> test/c_escape_unescaper_checker.sv
// Checker for the C escape decoder: predicts the response words and compares them.
`timescale 1ns / 1ps

module c_escape_unescaper_checker (
   input  logic clock,
   input  logic reset,
   cesc_req_if  req_mon,
   cesc_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   data_words,
   output int   good_ends,
   output int   bad_ends
);

   localparam int REPORT_LIMIT = 10;

   // Predicted decoder state
   cesc_pkg::mode_type dec_mode;
   logic [1:0]         dec_digits;
   logic [8:0]         dec_value;
   logic               dec_zero;
   logic [15:0]        dec_count;

   cesc_pkg::result_type step_words[$];
   cesc_pkg::result_type pending_words[$];
   cesc_pkg::result_type got_word;
   cesc_pkg::result_type want_word;

   function automatic int hex_weight(input logic [7:0] c);
      if (c >= cesc_pkg::CHAR_ZERO && c <= cesc_pkg::CHAR_NINE)
         return int'(c - cesc_pkg::CHAR_ZERO);
      if (c >= cesc_pkg::CHAR_LOWER_A && c <= cesc_pkg::CHAR_LOWER_F)
         return int'(c - cesc_pkg::CHAR_LOWER_A) + 10;
      if (c >= cesc_pkg::CHAR_UPPER_A && c <= cesc_pkg::CHAR_UPPER_F)
         return int'(c - cesc_pkg::CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   // Byte meant by a single-character escape, zero if there is none
   function automatic logic [7:0] simple_code(input logic [7:0] c);
      unique case (c)
         "'", "\"", "?", "\\": return c;
         "a": return 8'd7;
         "b": return 8'd8;
         "f": return 8'd12;
         "n": return 8'd10;
         "r": return 8'd13;
         "t": return 8'd9;
         "v": return 8'd11;
         default: return 8'd0;
      endcase
   endfunction

   function void clear_decoder();
      dec_mode   = cesc_pkg::MODE_NORMAL;
      dec_digits = 2'd0;
      dec_value  = 9'd0;
      dec_zero   = 1'b0;
      dec_count  = 16'd0;
   endfunction

   // Data word, unless an escape already produced a zero
   function void push_data(input logic [7:0] b);
      cesc_pkg::result_type w;
      if (!dec_zero) begin
         w = '{out_byte: b, kind: cesc_pkg::KIND_DATA, run_last: 1'b0, out_length: 16'd0};
         step_words.push_back(w);
         if (dec_count != 16'hFFFF) dec_count++;
      end
   endfunction

   function void close_escape();
      if (dec_value[7:0] == 8'd0) dec_zero = 1'b1;
      else push_data(dec_value[7:0]);
   endfunction

   function void take_plain(input logic [7:0] c);
      if (c == cesc_pkg::CHAR_BACKSLASH) begin
         dec_mode   = cesc_pkg::MODE_ESC;
         dec_digits = 2'd0;
         dec_value  = 9'd0;
      end else begin
         dec_mode = cesc_pkg::MODE_NORMAL;
         push_data(c);
      end
   endfunction

   // Work out the words one accepted request word causes
   function void decode_byte(input logic [7:0] c, input logic last);
      int                   h;
      logic                 oct;
      cesc_pkg::result_type w;
      h   = hex_weight(c);
      oct = (c >= cesc_pkg::CHAR_ZERO && c <= cesc_pkg::CHAR_SEVEN);
      step_words.delete();
      unique case (dec_mode)
         cesc_pkg::MODE_ERROR: ;
         cesc_pkg::MODE_ESC: begin
            if (simple_code(c) != 8'd0) begin
               dec_mode = cesc_pkg::MODE_NORMAL;
               push_data(simple_code(c));
            end else if (oct) begin
               dec_mode   = cesc_pkg::MODE_OCT;
               dec_digits = 2'd1;
               dec_value  = {6'd0, c[2:0]};
            end else if (c == cesc_pkg::CHAR_LOWER_X) begin
               dec_mode   = cesc_pkg::MODE_HEX0;
               dec_digits = 2'd0;
               dec_value  = 9'd0;
            end else begin
               dec_mode = cesc_pkg::MODE_ERROR;
            end
         end
         cesc_pkg::MODE_OCT: begin
            if (oct) begin
               if (dec_digits < 2'd2) begin
                  dec_value  = {dec_value[5:0], c[2:0]};
                  dec_digits = 2'd2;
               end else if (dec_value[8:3] > cesc_pkg::OCT_HIGH_MAX) begin
                  dec_mode = cesc_pkg::MODE_ERROR;
               end else begin
                  dec_value = {dec_value[5:0], c[2:0]};
                  close_escape();
                  dec_mode   = cesc_pkg::MODE_NORMAL;
                  dec_digits = 2'd0;
               end
            end else begin
               close_escape();
               take_plain(c);
            end
         end
         cesc_pkg::MODE_HEX0: begin
            if (h >= 0) begin
               dec_mode   = cesc_pkg::MODE_HEX;
               dec_digits = 2'd1;
               dec_value  = 9'(h);
            end else begin
               dec_mode = cesc_pkg::MODE_ERROR;
            end
         end
         cesc_pkg::MODE_HEX: begin
            if (h >= 0) begin
               if (dec_digits < 2'd2) begin
                  dec_value  = {dec_value[4:0], 4'(h)};
                  dec_digits = 2'd2;
               end else begin
                  dec_mode = cesc_pkg::MODE_ERROR;
               end
            end else begin
               close_escape();
               take_plain(c);
            end
         end
         default: take_plain(c);
      endcase

      // Close the string: flush or fail a pending escape, then the end word
      if (last) begin
         if (dec_mode == cesc_pkg::MODE_ESC || dec_mode == cesc_pkg::MODE_HEX0)
            dec_mode = cesc_pkg::MODE_ERROR;
         else if (dec_mode == cesc_pkg::MODE_OCT || dec_mode == cesc_pkg::MODE_HEX)
            close_escape();
         if (dec_mode == cesc_pkg::MODE_ERROR)
            w = '{out_byte: 8'd0, kind: cesc_pkg::KIND_END_BAD, run_last: 1'b0,
                  out_length: 16'd0};
         else
            w = '{out_byte: 8'd0, kind: cesc_pkg::KIND_END_OK, run_last: 1'b0,
                  out_length: dec_count};
         step_words.push_back(w);
         clear_decoder();
      end

      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.run_last = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
   endfunction

   function void note_failure();
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: word mismatch: expected byte %02h kind %0d last %0b len %0d,",
                  $realtime, want_word.out_byte, want_word.kind, want_word.run_last,
                  want_word.out_length,
                  " got byte %02h kind %0d last %0b len %0d",
                  got_word.out_byte, got_word.kind, got_word.run_last, got_word.out_length);
   endfunction

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         pending_words.delete();
         fail_count = 0;
         data_words = 0;
         good_ends  = 0;
         bad_ends   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_word = '{out_byte: rsp_mon.out_byte, kind: rsp_mon.kind,
                         run_last: rsp_mon.run_last, out_length: rsp_mon.out_length};
            if (got_word.kind == cesc_pkg::KIND_DATA) data_words++;
            else if (got_word.kind == cesc_pkg::KIND_END_OK) good_ends++;
            else bad_ends++;
            if (pending_words.size() == 0) begin
               want_word = '0;
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: response word with nothing expected: byte %02h kind %0d",
                           $realtime, got_word.out_byte, got_word.kind);
            end else begin
               want_word = pending_words.pop_front();
               if (got_word.out_byte != want_word.out_byte ||
                   got_word.kind != want_word.kind ||
                   got_word.run_last != want_word.run_last ||
                   got_word.out_length != want_word.out_length)
                  note_failure();
            end
         end
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.in_byte, req_mon.is_last);
      end
      outstanding = pending_words.size();
   end

endmodule

>>> test/c_escape_unescaper_core_tb.sv
// Testbench top for the C escape decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module c_escape_unescaper_core_tb;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 10;
   localparam int LONG_HOLD    = 150;
   localparam int RANDOM_BYTES = 250;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 600000;

   logic clock;
   logic reset;

   cesc_req_if req_bus ();
   cesc_rsp_if rsp_bus ();

   int   fail_count;
   int   outstanding;
   int   data_words;
   int   good_ends;
   int   bad_ends;
   int   send_idle_pct;
   int   rsp_idle_pct;
   logic hold_off_req;
   int   hold_count;
   int   cycle_count;
   int   bytes_sent;
   int   escape_turn;
   logic [7:0] text[$];

   c_escape_unescaper_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   c_escape_unescaper_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .data_words  (data_words),
      .good_ends   (good_ends),
      .bad_ends    (bad_ends)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_count   = 0;
            while (hold_count < LONG_HOLD) begin
               rsp_bus.ready <= 1'b0;
               hold_count++;
               @(negedge clock);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, outstanding);
      $display("c_escape_unescaper_core_tb: done, errors");
      $finish;
   end

   // Offer one word, with random gaps ahead of it, and wait until it is taken
   task automatic send_byte(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= c;
      req_bus.is_last <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endtask

   // Send the collected string, flagging its final byte
   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
      text.delete();
   endtask

   // Stop offering and wait for every expected word
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Mostly well-formed escapes with random content, some broken ones
   task automatic build_random_string();
      string      esc_set;
      string      hex_set;
      int         tokens;
      int         pick;
      int         ndig;
      logic [7:0] c;
      esc_set = "'\"?\\abfnrtv";
      hex_set = "0123456789abcdefABCDEF";
      tokens  = $urandom_range(1, 10);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            c = 8'($urandom_range(255));
            if (c == cesc_pkg::CHAR_BACKSLASH) c = 8'($urandom_range(8'h5D, 8'hFF));
            text.push_back(c);
         end else if (pick < 60) begin
            // rotate through the simple escapes so each one turns up
            text.push_back(cesc_pkg::CHAR_BACKSLASH);
            text.push_back(esc_set[escape_turn]);
            escape_turn = (escape_turn + 1) % esc_set.len();
         end else if (pick < 78) begin
            text.push_back(cesc_pkg::CHAR_BACKSLASH);
            ndig = $urandom_range(1, 3);
            if (ndig == 3) text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(0, 3)));
            else text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
            for (int d = 1; d < ndig; d++)
               text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
         end else if (pick < 92) begin
            text.push_back(cesc_pkg::CHAR_BACKSLASH);
            text.push_back(cesc_pkg::CHAR_LOWER_X);
            ndig = $urandom_range(1, 2);
            for (int d = 0; d < ndig; d++) text.push_back(hex_set[$urandom_range(21)]);
         end else begin
            text.push_back(cesc_pkg::CHAR_BACKSLASH);
            case ($urandom_range(3))
               0: text.push_back(8'($urandom_range(255)));
               1: begin
                  // octal with a high first digit and a third digit
                  text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(4, 7)));
                  text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
                  text.push_back(cesc_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
               end
               2: begin
                  text.push_back(cesc_pkg::CHAR_LOWER_X);
                  for (int d = 0; d < 3; d++) text.push_back(hex_set[$urandom_range(21)]);
               end
               default: begin
                  text.push_back(cesc_pkg::CHAR_LOWER_X);
                  text.push_back(8'($urandom_range(8'h67, 8'h7A)));
               end
            endcase
         end
      end
      // occasionally leave an escape hanging at the end
      if ($urandom_range(99) < 5) begin
         text.push_back(cesc_pkg::CHAR_BACKSLASH);
         if ($urandom_range(1)) text.push_back(cesc_pkg::CHAR_LOWER_X);
      end
   endtask

   // Stimulus
   initial begin
      int phase_goal;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'd0;
      req_bus.is_last = 1'b0;
      reset           = 1'b1;
      hold_off_req    = 1'b0;
      send_idle_pct   = 17;
      rsp_idle_pct    = 67;
      bytes_sent      = 0;
      escape_turn     = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings: byte extremes, escape corner cases
      text.push_back(8'h00);
      text.push_back(8'hFF);
      send_text();
      add_text("\\1017\\12");
      send_text();
      add_text("\\400");
      send_text();
      add_text("\\xFf");
      send_text();
      add_text("\\x123");
      send_text();
      add_text("\\xq");
      send_text();
      add_text("\\qz");
      send_text();
      add_text("\\");
      send_text();
      add_text("\\0\\t");
      send_text();
      wait_drained();

      // Random strings in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               rsp_idle_pct  = 67;
               hold_off_req  = 1'b1;
            end
            1: begin
               send_idle_pct = 67;
               rsp_idle_pct  = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         phase_goal = bytes_sent + RANDOM_BYTES / 3;
         while (bytes_sent < phase_goal) begin
            build_random_string();
            send_text();
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d request words in %0d strings (%0d good, %0d bad escape)",
               bytes_sent, good_ends + bad_ends, good_ends, bad_ends);
      $display("%0d data words checked over three stall mixes and one long receiver hold",
               data_words);
      if (fail_count == 0 && outstanding == 0)
         $display("c_escape_unescaper_core_tb: done, clean");
      else
         $display("c_escape_unescaper_core_tb: done, errors");
      $finish;
   end

endmodule
